// File: rtl/prm_pkg.sv
// ============================================================================
// prm_pkg
// Shared types and constants for the pedigree relationship matrix block.
// ============================================================================
package prm_pkg;

   localparam int DEF_MAX_ANIMALS = 256;

   localparam int VALUE_W  = 32;
   localparam int NUMBER_W = 9;
   localparam int ROWCOL_W = 8;
   localparam int INDEX_W  = 8;

   localparam logic [VALUE_W-1:0] ONE_Q30 = 32'h4000_0000;

   localparam logic ACTION_ADD  = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOOP,
      ST_DIAG,
      ST_FINISH
   } prm_state_type;

   typedef struct packed {
      logic load;
      logic rd_issue;
      logic loop_read;
      logic diag_read;
      logic finish;
   } prm_cmd_type;

   typedef struct packed {
      logic mode_read;
      logic read_err;
      logic add_err;
      logic add_first;
      logic loop_last;
      logic out_free;
   } prm_status_type;

endpackage

// File: rtl/pedigree_relationship_matrix_top.sv
// ============================================================================
// pedigree_relationship_matrix_top
// Additive relationship matrix built by the tabular method, one animal per
// add beat, with single-entry read back.
// ============================================================================
// One beat is worked at a time. A read beat, a rejected add or the first add
// goes from decode straight to the finishing state. An add of a later animal
// first walks over the earlier animals at one matrix entry per cycle through
// the two read ports of the store, then reads the entry of the two parents for
// the diagonal. The result register lets the next beat be accepted while a
// result is held.
// The store holds the lower triangle and needs no clearing after reset.
module pedigree_relationship_matrix_top #(
   parameter int MAX_ANIMALS = prm_pkg::DEF_MAX_ANIMALS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [prm_pkg::NUMBER_W-1:0]    req_sire_number,
   input  logic [prm_pkg::NUMBER_W-1:0]    req_dam_number,
   input  logic [prm_pkg::ROWCOL_W-1:0]    req_read_row,
   input  logic [prm_pkg::ROWCOL_W-1:0]    req_read_column,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [prm_pkg::VALUE_W-1:0]     rsp_relationship_value,
   output logic [prm_pkg::INDEX_W-1:0]     rsp_animal_index,
   output logic                            rsp_error_flag
);
   import prm_pkg::*;

   prm_cmd_type    cmd;
   prm_status_type status;

   prm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   prm_datapath #(
      .MAX_ANIMALS (MAX_ANIMALS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_action             (req_action),
      .req_sire_number        (req_sire_number),
      .req_dam_number         (req_dam_number),
      .req_read_row           (req_read_row),
      .req_read_column        (req_read_column),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_relationship_value (rsp_relationship_value),
      .rsp_animal_index       (rsp_animal_index),
      .rsp_error_flag         (rsp_error_flag)
   );

endmodule

// File: rtl/prm_ctrl.sv
// ============================================================================
// prm_ctrl
// Sequencer: decodes a beat, walks the row of a new animal, finishes result.
// ============================================================================
module prm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  prm_pkg::prm_status_type status,
   output prm_pkg::prm_cmd_type    cmd
);
   import prm_pkg::*;

   prm_state_type state_ff;
   prm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.mode_read) begin
               cmd.rd_issue = !status.read_err;
               state_in     = ST_FINISH;
            end else if (status.add_err || status.add_first) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            cmd.loop_read = 1'b1;
            if (status.loop_last) begin
               state_in = ST_DIAG;
            end
         end
         ST_DIAG: begin
            cmd.diag_read = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/prm_datapath.sv
// ============================================================================
// prm_datapath
// Beat registers, relationship store (lower triangle), row walk arithmetic
// and the result register.
// ============================================================================
module prm_datapath #(
   parameter int MAX_ANIMALS = prm_pkg::DEF_MAX_ANIMALS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  prm_pkg::prm_cmd_type            cmd,
   output prm_pkg::prm_status_type         status,
   input  logic                            req_action,
   input  logic [prm_pkg::NUMBER_W-1:0]    req_sire_number,
   input  logic [prm_pkg::NUMBER_W-1:0]    req_dam_number,
   input  logic [prm_pkg::ROWCOL_W-1:0]    req_read_row,
   input  logic [prm_pkg::ROWCOL_W-1:0]    req_read_column,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [prm_pkg::VALUE_W-1:0]     rsp_relationship_value,
   output logic [prm_pkg::INDEX_W-1:0]     rsp_animal_index,
   output logic                            rsp_error_flag
);
   import prm_pkg::*;

   localparam int IDX_W     = $clog2(MAX_ANIMALS);
   localparam int CNT_W     = $clog2(MAX_ANIMALS + 1);
   localparam int CMP_W     = (CNT_W > NUMBER_W) ? CNT_W : NUMBER_W;
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ANIMALS);

   function automatic logic [ADDR_W-1:0] lower_addr(input logic [IDX_W-1:0] a,
                                                    input logic [IDX_W-1:0] b);
      lower_addr = (a >= b) ? {a, b} : {b, a};
   endfunction

   logic                 action_ff;
   logic [NUMBER_W-1:0]  sire_ff;
   logic [NUMBER_W-1:0]  dam_ff;
   logic [ROWCOL_W-1:0]  row_ff;
   logic [ROWCOL_W-1:0]  col_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [IDX_W-1:0]     j_ff;
   logic [IDX_W-1:0]     wj_ff;
   logic                 wr_pend_ff;
   logic [VALUE_W-1:0]   rd0_ff;
   logic [VALUE_W-1:0]   rd1_ff;
   logic                 rsp_valid_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [INDEX_W-1:0]   index_ff;
   logic                 err_ff;

   logic [VALUE_W-1:0]   relationship_store [0:MEM_DEPTH-1];

   logic [CMP_W-1:0]     count_ext;
   logic [CMP_W-1:0]     sire_ext;
   logic [CMP_W-1:0]     dam_ext;
   logic [CMP_W-1:0]     row_ext;
   logic [CMP_W-1:0]     col_ext;
   logic [CMP_W-1:0]     sire_m1;
   logic [CMP_W-1:0]     dam_m1;
   logic [IDX_W-1:0]     s_idx;
   logic [IDX_W-1:0]     d_idx;
   logic [IDX_W-1:0]     i_idx;
   logic                 has_s;
   logic                 has_d;
   logic                 mode_read;
   logic                 read_err;
   logic                 add_err;
   logic                 add_first;
   logic [VALUE_W:0]     loop_sum;
   logic [VALUE_W-1:0]   diag_val;
   logic                 res_err;
   logic [VALUE_W-1:0]   res_val;
   logic                 diag_wr;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [VALUE_W-1:0]   wr_data;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd0_addr;
   logic [ADDR_W-1:0]    rd1_addr;
   logic [CNT_W-1:0]     count_in;

   assign count_ext = CMP_W'(count_ff);
   assign sire_ext  = CMP_W'(sire_ff);
   assign dam_ext   = CMP_W'(dam_ff);
   assign row_ext   = CMP_W'(row_ff);
   assign col_ext   = CMP_W'(col_ff);
   assign sire_m1   = sire_ext - CMP_W'(1);
   assign dam_m1    = dam_ext - CMP_W'(1);
   assign s_idx     = sire_m1[IDX_W-1:0];
   assign d_idx     = dam_m1[IDX_W-1:0];
   assign i_idx     = count_ff[IDX_W-1:0];
   assign has_s     = (sire_ff != '0);
   assign has_d     = (dam_ff != '0);

   assign mode_read = (action_ff == ACTION_READ);
   assign add_first = (count_ff == '0);
   assign read_err  = !((row_ext < count_ext) && (col_ext < count_ext));
   assign add_err   = (count_ext >= MAX_CMP) ||
                      (!add_first && ((sire_ext > count_ext) || (dam_ext > count_ext)));

   assign status.mode_read = mode_read;
   assign status.read_err  = read_err;
   assign status.add_err   = add_err;
   assign status.add_first = add_first;
   assign status.loop_last = ((CMP_W'(j_ff) + CMP_W'(1)) == count_ext);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // off-diagonal entry of the new row: half the sum over the known parents
   assign loop_sum = {1'b0, (has_s ? rd0_ff : '0)} + {1'b0, (has_d ? rd1_ff : '0)};
   assign diag_val = (has_s && has_d) ? (ONE_Q30 + {1'b0, rd0_ff[VALUE_W-1:1]}) : ONE_Q30;

   assign res_err = mode_read ? read_err : add_err;
   always_comb begin
      if (res_err) begin
         res_val = '0;
      end else if (mode_read) begin
         res_val = rd0_ff;
      end else if (add_first) begin
         res_val = ONE_Q30;
      end else begin
         res_val = diag_val;
      end
   end

   assign diag_wr = cmd.finish && !mode_read && !add_err;
   assign wr_en   = wr_pend_ff || diag_wr;
   assign wr_addr = wr_pend_ff ? {i_idx, wj_ff} : {i_idx, i_idx};
   assign wr_data = wr_pend_ff ? loop_sum[VALUE_W:1] : res_val;

   assign rd_en = cmd.rd_issue || cmd.loop_read || cmd.diag_read;
   always_comb begin
      if (cmd.rd_issue) begin
         rd0_addr = lower_addr(row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]);
      end else if (cmd.diag_read) begin
         rd0_addr = lower_addr(d_idx, s_idx);
      end else begin
         rd0_addr = lower_addr(s_idx, j_ff);
      end
   end
   assign rd1_addr = lower_addr(d_idx, j_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         relationship_store[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd0_ff <= relationship_store[rd0_addr];
         rd1_ff <= relationship_store[rd1_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         sire_ff   <= req_sire_number;
         dam_ff    <= req_dam_number;
         row_ff    <= req_read_row;
         col_ff    <= req_read_column;
      end
      if (cmd.load) begin
         j_ff <= '0;
      end else if (cmd.loop_read) begin
         j_ff <= j_ff + IDX_W'(1);
      end
      wj_ff <= j_ff;
      if (cmd.finish) begin
         value_ff <= res_val;
         index_ff <= mode_read ? row_ff : count_ext[INDEX_W-1:0];
         err_ff   <= res_err;
      end
   end

   assign count_in = diag_wr ? (count_ff + CNT_W'(1)) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         wr_pend_ff <= cmd.loop_read;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_relationship_value = value_ff;
   assign rsp_animal_index       = index_ff;
   assign rsp_error_flag         = err_ff;

endmodule

// File: rtl/prm_checker.sv
// ============================================================================
// prm_checker
// Port-level checks on the relationship matrix block, bound to the top level.
// ============================================================================
module prm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [prm_pkg::VALUE_W-1:0]     rsp_relationship_value,
   input logic [prm_pkg::INDEX_W-1:0]     rsp_animal_index,
   input logic                            rsp_error_flag
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_relationship_value) &&
         $stable(rsp_animal_index) && $stable(rsp_error_flag))
      else $error("stalled response beat changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous beat in work");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_flag |-> rsp_relationship_value == '0)
      else $error("rejected beat carries nonzero value");

endmodule

bind pedigree_relationship_matrix_top prm_checker u_prm_checker (.*);

// File: bench/tb_pedigree_relationship_matrix_top.sv
// ----------------------------------------------------------------------------
// tb_pedigree_relationship_matrix_top
// Self-checking bench for the tabular relationship matrix block. A scoreboard
// keeps its own copy of the matrix and the herd size. It predicts every
// response as the request beat is accepted and compares each returned beat
// field by field. A short directed pass covers founders, one-parent and
// two-parent adds, selfing, parents that come too late, and out-of-range
// reads. Random traffic then fills the herd to capacity, so that adds to a
// full table are rejected. Bursty requests and patterned response stalls
// run throughout.
// ----------------------------------------------------------------------------
module tb_pedigree_relationship_matrix_top;
   timeunit 1ns;
   timeprecision 1ps;

   import prm_pkg::*;

   localparam int HERD_MAX   = DEF_MAX_ANIMALS;
   localparam int BEAT_COUNT = 1400;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
      logic               flag;
   } kinship_result_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   class kinship_scoreboard;
      logic [VALUE_W-1:0] kinship [HERD_MAX][HERD_MAX];
      int unsigned        herd_size;
      kinship_result_type awaited[$];
      int unsigned        mismatches;

      function new();
         herd_size  = 0;
         mismatches = 0;
      endfunction

      function void note_beat(input logic action, input logic [NUMBER_W-1:0] sire,
                              input logic [NUMBER_W-1:0] dam,
                              input logic [ROWCOL_W-1:0] row,
                              input logic [ROWCOL_W-1:0] col);
         kinship_result_type res;
         int unsigned        s;
         int unsigned        d;
         logic [32:0]        wide;
         res = '0;
         if (action == ACTION_READ) begin
            res.index = row;
            if (row < herd_size && col < herd_size) begin
               res.value = kinship[row][col];
            end else begin
               res.flag = 1'b1;
            end
         end else begin
            res.index = 8'(herd_size);
            if (herd_size >= HERD_MAX) begin
               res.flag = 1'b1;
            end else if (herd_size == 0) begin
               kinship[0][0] = ONE_Q30;
               res.value     = ONE_Q30;
               herd_size     = 1;
            end else if (sire > herd_size || dam > herd_size) begin
               res.flag = 1'b1;
            end else begin
               s = (sire != 0) ? sire - 1 : 0;
               d = (dam != 0) ? dam - 1 : 0;
               for (int j = 0; j < herd_size; j++) begin
                  wide = '0;
                  if (sire != 0) wide += {1'b0, kinship[j][s]};
                  if (dam != 0) wide += {1'b0, kinship[j][d]};
                  kinship[herd_size][j] = wide[32:1];
                  kinship[j][herd_size] = wide[32:1];
               end
               if (sire != 0 && dam != 0) begin
                  wide = {1'b0, ONE_Q30} + {2'b00, kinship[d][s][31:1]};
                  res.value = wide[32] ? '1 : wide[31:0];
               end else begin
                  res.value = ONE_Q30;
               end
               kinship[herd_size][herd_size] = res.value;
               herd_size++;
            end
         end
         awaited.push_back(res);
      endfunction

      function void check_beat(input logic [VALUE_W-1:0] value,
                               input logic [INDEX_W-1:0] index, input logic flag);
         kinship_result_type exp;
         if (awaited.size() == 0) begin
            mismatches++;
            $display("%0t unexpected beat: value %h index %0d error %b",
                     $time, value, index, flag);
            return;
         end
         exp = awaited.pop_front();
         if (exp.value !== value) begin
            mismatches++;
            $display("%0t value: expected %h actual %h", $time, exp.value, value);
         end
         if (exp.index !== index) begin
            mismatches++;
            $display("%0t index: expected %0d actual %0d", $time, exp.index, index);
         end
         if (exp.flag !== flag) begin
            mismatches++;
            $display("%0t error flag: expected %b actual %b", $time, exp.flag, flag);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_action = ACTION_ADD;
   logic [NUMBER_W-1:0] req_sire_number = '0;
   logic [NUMBER_W-1:0] req_dam_number = '0;
   logic [ROWCOL_W-1:0] req_read_row = '0;
   logic [ROWCOL_W-1:0] req_read_column = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [VALUE_W-1:0]  rsp_relationship_value;
   logic [INDEX_W-1:0]  rsp_animal_index;
   logic                rsp_error_flag;

   kinship_scoreboard board = new();
   int unsigned       burst_left = 0;
   int unsigned       stall_cycle = 0;
   stall_style_type   stall_style = STALL_NONE;

   pedigree_relationship_matrix_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_sire_number       (req_sire_number),
      .req_dam_number        (req_dam_number),
      .req_read_row          (req_read_row),
      .req_read_column       (req_read_column),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_relationship_value(rsp_relationship_value),
      .rsp_animal_index      (rsp_animal_index),
      .rsp_error_flag        (rsp_error_flag)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic send_beat(input logic action, input logic [NUMBER_W-1:0] sire,
                            input logic [NUMBER_W-1:0] dam,
                            input logic [ROWCOL_W-1:0] row,
                            input logic [ROWCOL_W-1:0] col);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 15) == 0) ? 300 : $urandom_range(1, 20);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_action      <= action;
      req_sire_number <= sire;
      req_dam_number  <= dam;
      req_read_row    <= row;
      req_read_column <= col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_beat(action, sire, dam, row, col);
   endtask

   function automatic logic [NUMBER_W-1:0] pick_parent(input int unsigned herd);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (herd == 0 || roll < 15) return '0;
      if (roll < 65) return 9'(herd - $urandom_range(0, (herd > 8) ? 7 : herd - 1));
      return 9'($urandom_range(1, herd));
   endfunction

   // response side: check accepted beats, then pick next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_cycle <= 0;
         stall_style <= STALL_NONE;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            board.check_beat(rsp_relationship_value, rsp_animal_index, rsp_error_flag);
         end
         stall_cycle <= stall_cycle + 1;
         if (stall_cycle % 97 == 0) stall_style <= stall_style_type'($urandom_range(0, 3));
         case (stall_style)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= (stall_cycle % 24) < 14;
         endcase
      end
   end

   initial begin
      logic                action;
      logic [NUMBER_W-1:0] sire;
      logic [NUMBER_W-1:0] dam;
      logic [ROWCOL_W-1:0] row;
      logic [ROWCOL_W-1:0] col;
      int unsigned         herd;
      int unsigned         roll;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty table reads, founder with junk parents, small pedigree
      send_beat(ACTION_READ, 9'd0, 9'd0, 8'd0, 8'd0);
      send_beat(ACTION_READ, 9'h1FF, 9'h1FF, 8'hFF, 8'hFF);
      send_beat(ACTION_ADD, 9'h1FF, 9'h1FF, 8'hFF, 8'hFF);
      send_beat(ACTION_ADD, 9'd0, 9'd0, 8'd0, 8'd0);
      send_beat(ACTION_ADD, 9'd1, 9'd2, 8'd0, 8'd0);
      send_beat(ACTION_ADD, 9'd3, 9'd0, 8'd0, 8'd0);
      send_beat(ACTION_ADD, 9'd4, 9'd5, 8'd0, 8'd0);
      send_beat(ACTION_ADD, 9'd5, 9'd1, 8'd0, 8'd0);
      send_beat(ACTION_ADD, 9'd4, 9'd3, 8'd0, 8'd0);
      send_beat(ACTION_ADD, 9'd5, 9'd5, 8'd0, 8'd0);
      send_beat(ACTION_ADD, 9'd0, 9'd6, 8'd0, 8'd0);
      send_beat(ACTION_ADD, 9'd256, 9'd0, 8'd0, 8'd0);
      send_beat(ACTION_ADD, 9'd0, 9'd256, 8'd0, 8'd0);
      send_beat(ACTION_ADD, 9'h1FF, 9'd1, 8'd0, 8'd0);
      send_beat(ACTION_ADD, 9'd7, 9'd6, 8'd0, 8'd0);
      send_beat(ACTION_READ, 9'd0, 9'd0, 8'd0, 8'd0);
      send_beat(ACTION_READ, 9'd0, 9'd0, 8'd2, 8'd0);
      send_beat(ACTION_READ, 9'd0, 9'd0, 8'd5, 8'd5);
      send_beat(ACTION_READ, 9'd0, 9'd0, 8'd4, 8'd3);
      send_beat(ACTION_READ, 9'd0, 9'd0, 8'd7, 8'd6);
      send_beat(ACTION_READ, 9'd0, 9'd0, 8'd8, 8'd0);
      send_beat(ACTION_READ, 9'd0, 9'd0, 8'd0, 8'd8);
      send_beat(ACTION_READ, 9'h1FF, 9'h1FF, 8'hFF, 8'd0);

      for (int n = 0; n < BEAT_COUNT; n++) begin
         herd = board.herd_size;
         roll = $urandom_range(0, 99);
         sire = 9'($urandom);
         dam  = 9'($urandom);
         row  = 8'($urandom);
         col  = 8'($urandom);
         if (roll < 30) begin
            action = ACTION_ADD;
            if ($urandom_range(0, 19) != 0) begin
               sire = pick_parent(herd);
               dam  = pick_parent(herd);
            end
         end else begin
            action = ACTION_READ;
            if (herd != 0 && $urandom_range(0, 6) != 0) begin
               row = 8'($urandom_range(0, herd - 1));
               col = 8'($urandom_range(0, herd - 1));
            end
         end
         send_beat(action, sire, dam, row, col);
      end
      req_valid <= 1'b0;

      while (board.awaited.size() != 0) @(posedge clock);
      repeat (HERD_MAX + 8) @(posedge clock);
      if (board.mismatches == 0 && board.awaited.size() == 0) begin
         $display("tb_pedigree_relationship_matrix_top OK");
      end else begin
         $display("tb_pedigree_relationship_matrix_top NOT OK");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("tb_pedigree_relationship_matrix_top NOT OK");
      $finish;
   end

endmodule
